>>> rtl/ppq_pkg.sv
// shared types and constants of the priority play queue
package ppq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam logic [15:0] FADE_RESET = 16'd100;

   localparam logic [1:0] MODE_REQUEST = 2'd0;
   localparam logic [1:0] MODE_FINISH  = 2'd1;
   localparam logic [1:0] MODE_STOP    = 2'd2;
   localparam logic [1:0] MODE_CLEAR   = 2'd3;

   localparam logic [1:0] POL_INTERRUPT = 2'd0;
   localparam logic [1:0] POL_QUEUE     = 2'd1;

   localparam logic [1:0] REJ_NONE = 2'd0;
   localparam logic [1:0] REJ_NULL = 2'd1;
   localparam logic [1:0] REJ_DROP = 2'd2;
   localparam logic [1:0] REJ_FULL = 2'd3;

   typedef struct packed {
      logic [15:0] snd;
      logic [15:0] sub;
      logic [15:0] dur;
      logic [7:0]  spk;
      logic [1:0]  pri;
   } clip_type;

   typedef struct packed {
      logic     ins;
      logic     pop;
      logic     clr;
      clip_type clip;
   } q_cmd_type;

   typedef struct packed {
      logic     done;
      clip_type head;
   } q_sts_type;

   typedef enum logic [1:0] {
      Q_IDLE,
      Q_INS_RD,
      Q_INS_CHK,
      Q_POP
   } q_state_type;

   typedef enum logic {
      T_IDLE,
      T_WAIT
   } top_state_type;

endpackage

>>> rtl/preemptive_priority_play_queue.sv
// top level: play slot, event decode and result register
// One event is taken when start is high and busy is low; its result appears as a one-cycle
// rsp_valid strobe in the cycle after the event's last cycle and cannot be held off by the
// receiver. Requests that start or reject a clip, stop and clear events do not wait on the
// queue memory. A finished event with a non-empty queue makes one read of the queue memory
// for the head. A queue-behind insert into an empty queue writes the clip straight in; otherwise
// the insert walks back from the tail through the queue memory, moving each waiting entry of
// lower priority one slot towards the tail, one entry a cycle. busy is high while an event
// waits on the queue memory.
// The queue memory needs no clearing after reset.
module preemptive_priority_play_queue #(
   parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_sound_id,
   input  logic [15:0] req_subtitle_id,
   input  logic [15:0] req_duration_ms,
   input  logic [7:0]  req_speaker_id,
   input  logic [1:0]  req_priority_level,
   input  logic [1:0]  req_policy,
   input  logic [15:0] req_fade_ms,
   output logic        rsp_valid,
   output logic        rsp_accepted,
   output logic [1:0]  rsp_reject_reason,
   output logic        rsp_play_start,
   output logic        rsp_stop_current,
   output logic [15:0] rsp_stop_fade_ms,
   output logic [15:0] rsp_play_sound_id,
   output logic [15:0] rsp_play_subtitle_id,
   output logic [15:0] rsp_play_duration_ms,
   output logic [7:0]  rsp_play_speaker_id,
   output logic        rsp_is_playing,
   output logic [4:0]  rsp_queue_count,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import ppq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   top_state_type state_ff, state_in;
   q_cmd_type     qcmd;
   q_sts_type     qsts;
   logic [CW-1:0] q_count;

   logic          playing_ff, playing_in;
   logic [7:0]    speaker_ff, speaker_in;
   logic [15:0]   fade_ff, fade_in;
   logic          pend_pop_ff, pend_pop_in;

   logic          r_valid, r_acc, r_start, r_stop;
   logic [1:0]    r_rej;
   logic [15:0]   r_fade, r_snd, r_sub, r_dur;
   logic [CW-1:0] r_count;
   logic [CW+4:0] r_count_ext;

   logic          valid_ff, acc_ff, start_ff, stop_ff, playing_o_ff;
   logic [1:0]    rej_ff;
   logic [15:0]   fade_o_ff, snd_ff, sub_ff, dur_ff;
   logic [7:0]    spk_o_ff;
   logic [4:0]    count_o_ff;

   ppq_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (qcmd),
      .sts   (qsts),
      .count (q_count)
   );

   assign busy    = (state_ff == T_WAIT);
   assign fade_in = csr_we ? csr_wdata : fade_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: if (qcmd.ins || qcmd.pop) state_in = T_WAIT;
         T_WAIT: if (qsts.done) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      qcmd        = '0;
      qcmd.clip   = {req_sound_id, req_subtitle_id, req_duration_ms, req_speaker_id,
                     req_priority_level};
      playing_in  = playing_ff;
      speaker_in  = speaker_ff;
      pend_pop_in = pend_pop_ff;
      r_valid     = 1'b0;
      r_acc       = 1'b0;
      r_rej       = REJ_NONE;
      r_start     = 1'b0;
      r_stop      = 1'b0;
      r_fade      = '0;
      r_snd       = '0;
      r_sub       = '0;
      r_dur       = '0;
      r_count     = q_count;
      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               unique case (req_mode)
                  MODE_REQUEST: begin
                     if (req_sound_id == '0) begin
                        r_valid = 1'b1;
                        r_rej   = REJ_NULL;
                     end else if (!playing_ff || req_policy == POL_INTERRUPT) begin
                        r_valid    = 1'b1;
                        r_acc      = 1'b1;
                        r_start    = 1'b1;
                        r_snd      = req_sound_id;
                        r_sub      = req_subtitle_id;
                        r_dur      = req_duration_ms;
                        playing_in = 1'b1;
                        speaker_in = req_speaker_id;
                        if (playing_ff) begin
                           r_stop = 1'b1;
                           r_fade = fade_ff;
                        end
                     end else if (req_policy == POL_QUEUE) begin
                        if (q_count >= CW'(QUEUE_DEPTH)) begin
                           r_valid = 1'b1;
                           r_rej   = REJ_FULL;
                        end else begin
                           qcmd.ins    = 1'b1;
                           pend_pop_in = 1'b0;
                        end
                     end else begin
                        // drop and the unused policy code
                        r_valid = 1'b1;
                        r_rej   = REJ_DROP;
                     end
                  end
                  MODE_FINISH: begin
                     playing_in = 1'b0;
                     if (q_count != '0) begin
                        qcmd.pop    = 1'b1;
                        pend_pop_in = 1'b1;
                     end else begin
                        r_valid = 1'b1;
                     end
                  end
                  MODE_STOP: begin
                     r_valid    = 1'b1;
                     playing_in = 1'b0;
                     if (playing_ff) begin
                        r_stop = 1'b1;
                        r_fade = req_fade_ms;
                     end
                  end
                  MODE_CLEAR: begin
                     r_valid  = 1'b1;
                     qcmd.clr = 1'b1;
                     r_count  = '0;
                  end
                  default: ;
               endcase
            end
         end
         T_WAIT: begin
            if (qsts.done) begin
               r_valid = 1'b1;
               if (pend_pop_ff) begin
                  r_start    = 1'b1;
                  r_snd      = qsts.head.snd;
                  r_sub      = qsts.head.sub;
                  r_dur      = qsts.head.dur;
                  playing_in = 1'b1;
                  speaker_in = qsts.head.spk;
               end else begin
                  r_acc = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign r_count_ext = {5'b0, r_count};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= T_IDLE;
         playing_ff <= 1'b0;
         speaker_ff <= '0;
         fade_ff    <= FADE_RESET;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         playing_ff <= playing_in;
         speaker_ff <= speaker_in;
         fade_ff    <= fade_in;
         valid_ff   <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      pend_pop_ff  <= pend_pop_in;
      acc_ff       <= r_acc;
      rej_ff       <= r_rej;
      start_ff     <= r_start;
      stop_ff      <= r_stop;
      fade_o_ff    <= r_fade;
      snd_ff       <= r_snd;
      sub_ff       <= r_sub;
      dur_ff       <= r_dur;
      spk_o_ff     <= speaker_in;
      playing_o_ff <= playing_in;
      count_o_ff   <= r_count_ext[4:0];
   end

   assign rsp_valid            = valid_ff;
   assign rsp_accepted         = acc_ff;
   assign rsp_reject_reason    = rej_ff;
   assign rsp_play_start       = start_ff;
   assign rsp_stop_current     = stop_ff;
   assign rsp_stop_fade_ms     = fade_o_ff;
   assign rsp_play_sound_id    = snd_ff;
   assign rsp_play_subtitle_id = sub_ff;
   assign rsp_play_duration_ms = dur_ff;
   assign rsp_play_speaker_id  = spk_o_ff;
   assign rsp_is_playing       = playing_o_ff;
   assign rsp_queue_count      = count_o_ff;

   a_start_plays: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_play_start |-> rsp_is_playing)
      else $error("clip start reported with idle slot");

   a_accept_no_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_reject_reason == REJ_NONE)
      else $error("accepted beat carries a reject reason");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_wait_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_WAIT && qsts.done |=> rsp_valid && !busy)
      else $error("queue completion without result beat");

endmodule

>>> rtl/ppq_queue.sv
// sorted pending queue: circular buffer in one memory, insert by backward shift
module ppq_queue #(
   parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ppq_pkg::q_cmd_type                 cmd,
   output ppq_pkg::q_sts_type                 sts,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);
   import ppq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);

   clip_type    mem [QUEUE_DEPTH];
   clip_type    rd_data_ff;
   clip_type    clip_ff, clip_in;
   q_state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   clip_type      wr_data;
   logic          shift;
   logic [AW-1:0] idx_dec;

   // logical slot to physical address, head plus offset modulo depth
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] lg);
      logic [AW:0] s;
      s = {1'b0, hd} + {1'b0, lg};
      if (s >= DEPTH_W) s = s - DEPTH_W;
      return s[AW-1:0];
   endfunction

   assign shift   = (rd_data_ff.pri < clip_ff.pri);
   assign idx_dec = idx_ff - AW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         Q_IDLE: begin
            if (cmd.clr) state_in = Q_IDLE;
            else if (cmd.ins) state_in = Q_INS_RD;
            else if (cmd.pop) state_in = Q_POP;
         end
         Q_INS_RD: begin
            if (idx_ff == '0) state_in = Q_IDLE;
            else state_in = Q_INS_CHK;
         end
         Q_INS_CHK: begin
            if (!shift) state_in = Q_IDLE;
            else if (idx_dec == '0) state_in = Q_INS_RD;
         end
         Q_POP: state_in = Q_IDLE;
         default: state_in = Q_IDLE;
      endcase
   end

   always_comb begin
      head_in  = head_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      clip_in  = clip_ff;
      rd_en    = 1'b0;
      rd_addr  = phys(head_ff, idx_dec);
      wr_en    = 1'b0;
      wr_addr  = phys(head_ff, idx_ff);
      wr_data  = clip_ff;
      sts.done = 1'b0;
      sts.head = rd_data_ff;
      unique case (state_ff)
         Q_IDLE: begin
            if (cmd.clr) begin
               count_in = '0;
            end else if (cmd.ins) begin
               count_in = count_ff + CW'(1);
               idx_in   = count_ff[AW-1:0];
               clip_in  = cmd.clip;
            end else if (cmd.pop) begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               head_in  = phys(head_ff, AW'(1));
               count_in = count_ff - CW'(1);
            end
         end
         Q_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               sts.done = 1'b1;
            end else begin
               rd_en = 1'b1;
            end
         end
         Q_INS_CHK: begin
            wr_en = 1'b1;
            if (shift) begin
               // lower priority entry moves one slot towards the tail
               wr_data = rd_data_ff;
               idx_in  = idx_dec;
               if (idx_dec != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = phys(head_ff, idx_dec - AW'(1));
               end
            end else begin
               sts.done = 1'b1;
            end
         end
         Q_POP: sts.done = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      clip_ff <= clip_in;
   end

   assign count = count_ff;

endmodule
